FILE: design/coc_pkg.sv
// Shared types, constants and operation codes of the co-occurrence counter.
package coc_pkg;

	localparam int NUM_CUES_DEF           = 64;
	localparam int NUM_OUTCOMES_DEF       = 64;
	localparam int MAX_EVENT_CUES_DEF     = 16;
	localparam int MAX_EVENT_OUTCOMES_DEF = 16;

	localparam int OP_W   = 3;
	localparam int IDX_W  = 6;
	localparam int CNT_W  = 32;
	localparam int STAT_W = 2;

	typedef enum logic [OP_W-1:0] {
		OP_ADD_CUE     = 3'd0,
		OP_ADD_OUTCOME = 3'd1,
		OP_CLOSE       = 3'd2,
		OP_READ_CC     = 3'd3,
		OP_READ_CO     = 3'd4,
		OP_READ_BG     = 3'd5
	} op_t;

	localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
	localparam logic [STAT_W-1:0] ST_SAT  = 2'd2;

	localparam logic CFG_REMOVE_DUP = 1'b0;
	localparam logic CFG_ADD_BG     = 1'b1;

	// Request from the sequencer naming the bank and address of the counter that the shared saturating adder updates.
	typedef struct packed {
		logic       go;
		logic [1:0] bank;
		logic [11:0] addr;
	} bump_req_t;

	localparam logic [1:0] BANK_CC = 2'd0;
	localparam logic [1:0] BANK_CO = 2'd1;
	localparam logic [1:0] BANK_BG = 2'd2;

endpackage

FILE: design/coc_sat_add.sv
// Shared saturating adder used for every counter update.
module coc_sat_add (
	input  logic [coc_pkg::CNT_W-1:0] acc,
	input  logic [coc_pkg::CNT_W-1:0] freq,
	output logic [coc_pkg::CNT_W-1:0] sum,
	output logic                      sat
);
	import coc_pkg::*;

	logic [CNT_W:0] wide;

	always_comb begin
		wide = {1'b0, acc} + {1'b0, freq};
		sat  = wide[CNT_W];
		sum  = wide[CNT_W] ? {CNT_W{1'b1}} : wide[CNT_W-1:0];
	end
endmodule

FILE: design/cue_outcome_cooccurrence_counter_core.sv
// Top level of the cue/outcome co-occurrence counter.
// Add cue / add outcome scan the event list one entry a cycle (outcomes always, cues only
// when duplicates are removed). Reads: memory read, register, result. A close event plans,
// reads and writes each counter update through the shared adder; other walk steps only plan.
// One item at a time: the next is accepted the cycle after the result is taken.
// After reset a clearing pass of max(NUM_CUES*NUM_CUES, NUM_CUES*NUM_OUTCOMES) entries zeroes
// the counter memories; no item is accepted meanwhile. Reset is asynchronous, active low.
module cue_outcome_cooccurrence_counter_core #(
	parameter int NUM_CUES           = coc_pkg::NUM_CUES_DEF,
	parameter int NUM_OUTCOMES       = coc_pkg::NUM_OUTCOMES_DEF,
	parameter int MAX_EVENT_CUES     = coc_pkg::MAX_EVENT_CUES_DEF,
	parameter int MAX_EVENT_OUTCOMES = coc_pkg::MAX_EVENT_OUTCOMES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// tdata: operation[2:0], first_index[8:3], second_index[14:9], frequency[46:15], pad
	input  logic [47:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// tdata: read_value[31:0], status[33:32], pad
	output logic [39:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic        cfg_data
);
	import coc_pkg::*;

	localparam int CW  = (NUM_CUES > 1) ? $clog2(NUM_CUES) : 1;
	localparam int OW  = (NUM_OUTCOMES > 1) ? $clog2(NUM_OUTCOMES) : 1;
	localparam int LCW = (MAX_EVENT_CUES > 1) ? $clog2(MAX_EVENT_CUES) : 1;
	localparam int LOW = (MAX_EVENT_OUTCOMES > 1) ? $clog2(MAX_EVENT_OUTCOMES) : 1;
	localparam int CCD = NUM_CUES * NUM_CUES;
	localparam int COD = NUM_CUES * NUM_OUTCOMES;
	localparam int CLR_N = (CCD > COD) ? CCD : COD;
	localparam int CLRW = $clog2(CLR_N + 1);

	// Sequencer states, one-hot.
	typedef enum logic [9:0] {
		S_CLEAR = 10'b0000000001,
		S_IDLE  = 10'b0000000010,
		S_SCAN  = 10'b0000000100,
		S_RD    = 10'b0000001000,
		S_RD2   = 10'b0000010000,
		S_CPLAN = 10'b0000100000,
		S_CRD   = 10'b0001000000,
		S_CWR   = 10'b0010000000,
		S_OUT   = 10'b0100000000,
		S_WAIT  = 10'b1000000000
	} state_t;

	state_t state_q;

	logic remove_dup_q, add_bg_q;
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remove_dup_q <= 1'b0;
			add_bg_q     <= 1'b0;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_REMOVE_DUP) remove_dup_q <= cfg_data;
			else add_bg_q <= cfg_data;
		end
	end

	// Event lists: small register arrays read at the walk and scan indices.
	logic [CW-1:0] cues_q [MAX_EVENT_CUES];
	logic [OW-1:0] outs_q [MAX_EVENT_OUTCOMES];
	logic [LCW:0] ncue_q;
	logic [LOW:0] nout_q;

	// Counter memories.
	logic [CNT_W-1:0] cc_mem [CCD];
	logic [CNT_W-1:0] co_mem [COD];
	logic [CNT_W-1:0] bg_mem [NUM_OUTCOMES];

	// Latched item.
	op_t              op_q;
	logic [IDX_W-1:0] a_q, b_q;
	logic [CNT_W-1:0] f_q;

	logic [CLRW-1:0] clr_q;
	logic [LCW:0] i_q, j_q; // outer and inner indices (also scan index)
	logic [LOW:0] k_q;
	logic [1:0]  phase_q;    // 0 diag, 1 pairs, 2 cue-outcome, 3 background
	logic        mirror_q;
	logic        sat_q;
	logic [CNT_W-1:0] rdata_q, res_val_q;
	logic [STAT_W-1:0] res_st_q;
	bump_req_t req_q;

	logic [CNT_W-1:0] sum;
	logic             sat_now;
	coc_sat_add u_add (.acc(rdata_q), .freq(f_q), .sum(sum), .sat(sat_now));

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = (state_q == S_WAIT);
	assign m_tdata  = {6'd0, res_st_q, res_val_q};

	// Next planned update during close; computed from i/j/k and phase.
	logic [CW-1:0] ca, cb;
	logic [OW-1:0] oj;
	always_comb begin
		ca = cues_q[i_q[LCW-1:0]];
		cb = cues_q[j_q[LCW-1:0]];
		oj = outs_q[k_q[LOW-1:0]];
	end

	logic [11:0] plan_addr;
	logic [1:0]  plan_bank;
	logic        plan_ok, plan_done;
	always_comb begin
		plan_addr = '0;
		plan_bank = BANK_CC;
		plan_ok   = 1'b0;
		plan_done = 1'b0;
		case (phase_q)
			2'd0: begin
				if (i_q >= ncue_q) begin
					plan_done = 1'b0;
				end else begin
					plan_ok   = 1'b1;
					plan_addr = 12'(ca * NUM_CUES + ca);
				end
			end
			2'd1: begin
				if (j_q < ncue_q && ca != cb) begin
					plan_ok   = 1'b1;
					plan_addr = mirror_q ? 12'(cb * NUM_CUES + ca) : 12'(ca * NUM_CUES + cb);
				end
			end
			2'd2: begin
				plan_ok   = (k_q < nout_q);
				plan_bank = BANK_CO;
				plan_addr = 12'(ca * NUM_OUTCOMES + oj);
			end
			default: begin
				plan_ok   = add_bg_q && (k_q < nout_q);
				plan_bank = BANK_BG;
				plan_addr = 12'(oj);
				plan_done = !plan_ok;
			end
		endcase
	end

	// Memory port: one read and one write per cycle.
	always_ff @(posedge clk) begin
		if (state_q == S_CLEAR) begin
			if (clr_q < CCD) cc_mem[clr_q[$clog2(CCD)-1:0]] <= '0;
			if (clr_q < COD) co_mem[clr_q[$clog2(COD)-1:0]] <= '0;
			if (clr_q < NUM_OUTCOMES) bg_mem[clr_q[OW-1:0]] <= '0;
		end else if (state_q == S_CWR) begin
			case (req_q.bank)
				BANK_CC: cc_mem[req_q.addr[$clog2(CCD)-1:0]] <= sum;
				BANK_CO: co_mem[req_q.addr[$clog2(COD)-1:0]] <= sum;
				default: bg_mem[req_q.addr[OW-1:0]] <= sum;
			endcase
		end
		if (state_q == S_CRD) begin
			case (req_q.bank)
				BANK_CC: rdata_q <= cc_mem[req_q.addr[$clog2(CCD)-1:0]];
				BANK_CO: rdata_q <= co_mem[req_q.addr[$clog2(COD)-1:0]];
				default: rdata_q <= bg_mem[req_q.addr[OW-1:0]];
			endcase
		end else if (state_q == S_RD) begin
			case (op_q)
				OP_READ_CC: rdata_q <= cc_mem[12'(a_q[CW-1:0] * NUM_CUES + b_q[CW-1:0])];
				OP_READ_CO: rdata_q <= co_mem[12'(a_q[CW-1:0] * NUM_OUTCOMES + b_q[OW-1:0])];
				default:    rdata_q <= bg_mem[a_q[OW-1:0]];
			endcase
		end
	end

	logic scan_hit_c, scan_hit_o;
	assign scan_hit_c = (i_q < ncue_q) && (cues_q[i_q[LCW-1:0]] == a_q[CW-1:0]);
	assign scan_hit_o = (k_q < nout_q) && (outs_q[k_q[LOW-1:0]] == a_q[OW-1:0]);

	// A cue is appended at once when duplicates are kept, otherwise after a scan
	// of the whole list finds no match.
	logic cue_app, out_app;
	assign cue_app = (state_q == S_SCAN) && (op_q == OP_ADD_CUE) && (32'(a_q) < NUM_CUES)
		&& !(remove_dup_q && scan_hit_c) && (!remove_dup_q || i_q == ncue_q)
		&& (ncue_q < MAX_EVENT_CUES);
	assign out_app = (state_q == S_SCAN) && (op_q == OP_ADD_OUTCOME)
		&& (32'(a_q) < NUM_OUTCOMES) && !scan_hit_o && (k_q == nout_q)
		&& (nout_q < MAX_EVENT_OUTCOMES);

	always_ff @(posedge clk) begin
		if (cue_app)
			cues_q[ncue_q[LCW-1:0]] <= a_q[CW-1:0];
		if (out_app)
			outs_q[nout_q[LOW-1:0]] <= a_q[OW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			ncue_q  <= '0;
			nout_q  <= '0;
			i_q <= '0; j_q <= '0; k_q <= '0;
			phase_q <= 2'd0; mirror_q <= 1'b0;
			sat_q <= 1'b0;
			req_q <= '0;
			op_q <= OP_ADD_CUE; a_q <= '0; b_q <= '0; f_q <= '0;
			res_val_q <= '0; res_st_q <= ST_OK;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLRW'(CLR_N - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (s_tvalid) begin
						op_q <= op_t'(s_tdata[2:0]);
						a_q  <= s_tdata[8:3];
						b_q  <= s_tdata[14:9];
						f_q  <= s_tdata[46:15];
						i_q <= '0; j_q <= '0; k_q <= '0;
						phase_q <= 2'd0; mirror_q <= 1'b0;
						sat_q <= 1'b0;
						res_val_q <= '0; res_st_q <= ST_OK;
						case (s_tdata[2:0])
							OP_ADD_CUE, OP_ADD_OUTCOME: state_q <= S_SCAN;
							OP_READ_CC, OP_READ_CO, OP_READ_BG: state_q <= S_RD;
							OP_CLOSE: state_q <= S_CPLAN;
							default: state_q <= S_WAIT;
						endcase
					end
				end
				S_SCAN: begin
					if (op_q == OP_ADD_CUE) begin
						if (32'(a_q) >= NUM_CUES) state_q <= S_WAIT;
						else if (remove_dup_q && scan_hit_c) state_q <= S_WAIT;
						else if (!remove_dup_q || i_q == ncue_q) begin
							if (ncue_q < MAX_EVENT_CUES) ncue_q <= ncue_q + 1'b1;
							else res_st_q <= ST_FULL;
							state_q <= S_WAIT;
						end else i_q <= i_q + 1'b1;
					end else begin
						if (32'(a_q) >= NUM_OUTCOMES) state_q <= S_WAIT;
						else if (scan_hit_o) state_q <= S_WAIT;
						else if (k_q == nout_q) begin
							if (nout_q < MAX_EVENT_OUTCOMES) nout_q <= nout_q + 1'b1;
							else res_st_q <= ST_FULL;
							state_q <= S_WAIT;
						end else k_q <= k_q + 1'b1;
					end
				end
				S_RD: state_q <= S_RD2;
				S_RD2: begin
					if ((op_q == OP_READ_CC && 32'(a_q) < NUM_CUES && 32'(b_q) < NUM_CUES) ||
						(op_q == OP_READ_CO && 32'(a_q) < NUM_CUES && 32'(b_q) < NUM_OUTCOMES) ||
						(op_q == OP_READ_BG && 32'(a_q) < NUM_OUTCOMES))
						res_val_q <= rdata_q;
					state_q <= S_WAIT;
				end
				S_CPLAN: begin
					// Issue the planned update, then advance the walk.
					if (plan_ok) begin
						req_q.go <= 1'b1; req_q.bank <= plan_bank; req_q.addr <= plan_addr;
						state_q <= S_CRD;
					end
					case (phase_q)
						2'd0: begin
							if (i_q >= ncue_q) begin
								phase_q <= 2'd3; k_q <= '0;
							end else begin
								phase_q <= 2'd1; j_q <= i_q + 1'b1; mirror_q <= 1'b0;
							end
						end
						2'd1: begin
							if (j_q >= ncue_q) begin
								phase_q <= 2'd2; k_q <= '0;
							end else if (plan_ok && !mirror_q) mirror_q <= 1'b1;
							else begin
								mirror_q <= 1'b0; j_q <= j_q + 1'b1;
							end
						end
						2'd2: begin
							if (k_q >= nout_q) begin
								phase_q <= 2'd0; i_q <= i_q + 1'b1;
							end else k_q <= k_q + 1'b1;
						end
						default: begin
							if (plan_done) begin
								state_q <= S_OUT;
							end else k_q <= k_q + 1'b1;
						end
					endcase
				end
				S_CRD: state_q <= S_CWR;
				S_CWR: begin
					if (sat_now) sat_q <= 1'b1;
					state_q <= S_CPLAN;
				end
				S_OUT: begin
					ncue_q <= '0; nout_q <= '0;
					if (sat_q) res_st_q <= ST_SAT;
					state_q <= S_WAIT;
				end
				S_WAIT: if (m_tready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

FILE: design/coc_checker.sv
// Port-level checker for the co-occurrence counter, bound to the top level.
module coc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata
);
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("input taken while result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[33:32] != 2'd3) else $error("bad status");
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready) else $error("ready after accept");
endmodule

bind cue_outcome_cooccurrence_counter_core coc_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
